// ===== rtl/brr_pkg.sv =====
// Shared types and constants for the bounded random range reducer.
`default_nettype none

package brr_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned FU_W   = 4;
	localparam int unsigned STAT_W = 2;

	// Result status codes
	localparam logic [STAT_W-1:0] STATUS_OK           = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_RANGE    = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_ENTROPY_FAIL = 2'd2;

	// One input request
	typedef struct packed {
		logic [WORD_W-1:0] range_high;
		logic [WORD_W-1:0] range_low;
		logic              entropy_fail;
		logic [WORD_W-1:0] random_word;
	} brr_item_t;

	// State carried between requests
	typedef struct packed {
		logic              busy;
		logic [WORD_W-1:0] int_part;
		logic [WORD_W-1:0] frac_part;
		logic [WORD_W-1:0] span;
		logic [WORD_W-1:0] base;
		logic [FU_W-1:0]   followups;
	} brr_state_t;

	// Result of one step
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] value;
		logic [STAT_W-1:0] status;
	} brr_result_t;

endpackage

`default_nettype wire

// ===== rtl/brr_step.sv =====
// Combinational step: one multiply, fraction add and decision per item.
`default_nettype none

module brr_step
	import brr_pkg::*;
#(
	parameter int unsigned FOLLOWUP_LIMIT = 10
) (
	input  brr_state_t  state,
	input  brr_item_t   item,
	output brr_state_t  state_next,
	output brr_result_t result
);

	localparam logic [FU_W-1:0] LIMIT_C = FU_W'(FOLLOWUP_LIMIT);

	logic [WORD_W-1:0]   span_new;
	logic [WORD_W-1:0]   span_op;
	logic [2*WORD_W-1:0] prod;
	logic [WORD_W-1:0]   prod_hi;
	logic [WORD_W-1:0]   prod_lo;
	logic [WORD_W:0]     sum;
	logic [WORD_W-1:0]   neg_span;
	logic [WORD_W-1:0]   idle_val;
	logic [WORD_W-1:0]   busy_val;
	logic [FU_W-1:0]     fu_inc;

	// Shared multiplier: span of the new request when idle, stored span otherwise
	assign span_new = item.range_high - item.range_low;
	assign span_op  = state.busy ? state.span : span_new;
	assign prod     = {{WORD_W{1'b0}}, span_op} * {{WORD_W{1'b0}}, item.random_word};
	assign prod_hi  = prod[2*WORD_W-1:WORD_W];
	assign prod_lo  = prod[WORD_W-1:0];

	// Fraction extension and result adders
	assign sum      = {1'b0, state.frac_part} + {1'b0, prod_hi};
	assign neg_span = '0 - span_new;
	assign idle_val = item.range_low + prod_hi;
	assign busy_val = state.base + state.int_part + {{(WORD_W-1){1'b0}}, sum[WORD_W]};
	assign fu_inc   = state.followups + FU_W'(1);

	always_comb begin
		state_next    = state;
		result.valid  = 1'b0;
		result.value  = '0;
		result.status = STATUS_OK;
		if (!state.busy) begin
			if (item.range_low >= item.range_high) begin
				result.valid  = 1'b1;
				result.status = STATUS_BAD_RANGE;
			end else begin
				state_next.base = item.range_low;
				state_next.span = span_new;
				if (span_new == WORD_W'(1)) begin
					result.valid = 1'b1;
					result.value = item.range_low;
				end else if (item.entropy_fail) begin
					result.valid  = 1'b1;
					result.value  = item.range_low;
					result.status = STATUS_ENTROPY_FAIL;
				end else begin
					state_next.int_part  = prod_hi;
					state_next.frac_part = prod_lo;
					if (prod_lo <= neg_span) begin
						result.valid = 1'b1;
						result.value = idle_val;
					end else begin
						state_next.followups = '0;
						state_next.busy      = 1'b1;
					end
				end
			end
		end else if (item.entropy_fail) begin
			result.valid    = 1'b1;
			result.value    = state.base;
			result.status   = STATUS_ENTROPY_FAIL;
			state_next.busy = 1'b0;
		end else if (sum[WORD_W] || (sum[WORD_W-1:0] != '1)) begin
			// carry gives candidate + 1, any other non-all-ones sum the candidate
			result.valid    = 1'b1;
			result.value    = busy_val;
			state_next.busy = 1'b0;
		end else begin
			// undecided: keep going until the follow-up limit
			state_next.frac_part = prod_lo;
			state_next.followups = fu_inc;
			if (fu_inc >= LIMIT_C) begin
				result.valid    = 1'b1;
				result.value    = busy_val;
				state_next.busy = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bounded_random_range_reducer.sv =====
// Top level of the bounded random range reducer: input register, state and result register.
//
// Usage: each request on the slave stream carries one random word, an entropy-fail
// flag and a half-open range [range_low, range_high). The range is only read when no
// draw is pending; while a draw needs follow-up words, later requests supply just the
// random word (their range is ignored). A request yields zero or one result on the
// master stream: the chosen value with status 0 (ok), 1 (bad range, value 0) or
// 2 (entropy failure, value = low bound of the pending draw).
// A request accepted into the input register is processed as it moves on into the result
// register, which presents its result from then on.
// Throughput: one request per cycle while the receiver does not stall; the single 32x32
// multiplier plus the fraction add and compare sit combinationally between the input and result registers.
// Reset clears the pending draw and empties both registers.
// When the receiver stalls, the result register holds; one further request is parked
// in the input register, and then s_axis_tready drops until the result is taken.
`default_nettype none

module bounded_random_range_reducer
	import brr_pkg::*;
#(
	parameter int unsigned FOLLOWUP_LIMIT = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // random_word, range_low, range_high
	input  wire logic [0:0]  s_axis_tuser,  // entropy_fail
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // value
	output logic [1:0]       m_axis_tuser   // status
);

	logic        valid_s1;
	brr_item_t   item_s1;
	brr_state_t  state_q;
	brr_state_t  state_next;
	brr_result_t result;
	logic        out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	logic [STAT_W-1:0] out_status_q;
	logic        advance;

	// Item in the input register moves on when the result register is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.random_word  <= s_axis_tdata[31:0];
			item_s1.range_low    <= s_axis_tdata[63:32];
			item_s1.range_high   <= s_axis_tdata[95:64];
			item_s1.entropy_fail <= s_axis_tuser[0];
		end
	end

	brr_step #(
		.FOLLOWUP_LIMIT(FOLLOWUP_LIMIT)
	) u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result)
	);

	// Draw state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_value_q  <= result.value;
			out_status_q <= result.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_status_q;

	// Checks
	a_bad_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STATUS_BAD_RANGE) |-> m_axis_tdata == '0)
		else $error("bad range result with nonzero value");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_BAD_RANGE ||
			m_axis_tuser == STATUS_ENTROPY_FAIL))
		else $error("illegal status code");

	a_fu_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.busy |-> state_q.followups < FU_W'(FOLLOWUP_LIMIT))
		else $error("pending draw past follow-up limit");

	a_bad_range_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !state_q.busy && item_s1.range_low >= item_s1.range_high) |=>
			(out_valid_q && out_status_q == STATUS_BAD_RANGE && !state_q.busy))
		else $error("bad range request did not produce a result");

endmodule

`default_nettype wire
